@@ rtl/rhpq_pkg.sv @@
// Shared widths, codes and sideband types for the palette quantizer.
`default_nettype none
package rhpq_pkg;

    localparam int CH_W   = 8;
    localparam int Q_W    = 7;
    localparam int NUM_W  = 11;
    localparam int DIV_W  = 11;
    localparam int PROD_W = 18;
    localparam int QUO_W  = 7;
    localparam int IDX_W  = 8;

    localparam logic [Q_W-1:0] Q_MIN   = 7'd32;
    localparam logic [Q_W-1:0] Q_MAX   = 7'd64;
    localparam logic [Q_W-1:0] Q_RESET = 7'd64;

    localparam logic [1:0] GREY_BLACK = 2'd0;
    localparam logic [1:0] GREY_WHITE = 2'd1;
    localparam logic [1:0] GREY_LIGHT = 2'd2;
    localparam logic [1:0] GREY_MID   = 2'd3;

    typedef struct packed {
        logic       grey;
        logic [1:0] grey_code;
        logic       hi_val;
        logic       hi_sat;
    } t_side;

endpackage
`default_nettype wire

@@ rtl/rhpq_if.sv @@
// Stream interfaces for pixel words and palette index words.
`default_nettype none
interface rhpq_pix_if;
    logic                    valid;
    logic                    ready;
    logic [rhpq_pkg::CH_W-1:0] red;
    logic [rhpq_pkg::CH_W-1:0] green;
    logic [rhpq_pkg::CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhpq_idx_if;
    logic                       valid;
    logic                       ready;
    logic [rhpq_pkg::IDX_W-1:0] palette_index;

    modport source (output valid, output palette_index, input ready);
    modport sink   (input valid, input palette_index, output ready);
endinterface
`default_nettype wire

@@ rtl/rhpq_hue_front.sv @@
// Two front stages: channel max/min and hue sector numerator, grey test.
`default_nettype none
module rhpq_hue_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_vld,
    input  wire logic [rhpq_pkg::CH_W-1:0]   i_red,
    input  wire logic [rhpq_pkg::CH_W-1:0]   i_green,
    input  wire logic [rhpq_pkg::CH_W-1:0]   i_blue,
    output logic                             o_vld,
    output logic [rhpq_pkg::NUM_W-1:0]       o_num,
    output logic [rhpq_pkg::CH_W-1:0]        o_span,
    output rhpq_pkg::t_side                  o_side
);

    localparam logic [1:0] K_ONE   = 2'd0;
    localparam logic [1:0] K_THREE = 2'd1;
    localparam logic [1:0] K_FIVE  = 2'd2;

    function automatic logic [rhpq_pkg::NUM_W-1:0] NUM_W_EXT(
        input logic [rhpq_pkg::CH_W-1:0] v
    );
        return {{(rhpq_pkg::NUM_W - rhpq_pkg::CH_W){1'b0}}, v};
    endfunction

    logic [rhpq_pkg::CH_W-1:0] w_mx, w_mn, w_chan;
    logic [1:0]                w_k;
    logic                      w_sub;

    logic [rhpq_pkg::CH_W-1:0] r_mx, r_mn, r_chan;
    logic [1:0]                r_k;
    logic                      r_sub;
    logic                      r_vld1;

    logic [rhpq_pkg::CH_W-1:0]  w_d, w_t;
    logic [rhpq_pkg::NUM_W-1:0] w_dx, w_kd, w_num, w_d5;
    rhpq_pkg::t_side            w_side;

    logic [rhpq_pkg::NUM_W-1:0] r_num;
    logic [rhpq_pkg::CH_W-1:0]  r_span;
    rhpq_pkg::t_side            r_side;
    logic                       r_vld2;

    always_comb begin
        w_mx = i_red;
        if (i_green > w_mx) w_mx = i_green;
        if (i_blue > w_mx) w_mx = i_blue;
        w_mn = i_red;
        if (i_green < w_mn) w_mn = i_green;
        if (i_blue < w_mn) w_mn = i_blue;
        if (w_mx == i_blue) begin
            if (w_mn == i_red) begin
                w_k = K_THREE; w_sub = 1'b0; w_chan = i_green;
            end else begin
                w_k = K_FIVE;  w_sub = 1'b1; w_chan = i_red;
            end
        end else if (w_mx == i_green) begin
            if (w_mn == i_blue) begin
                w_k = K_ONE;   w_sub = 1'b0; w_chan = i_red;
            end else begin
                w_k = K_THREE; w_sub = 1'b1; w_chan = i_blue;
            end
        end else begin
            if (w_mn == i_green) begin
                w_k = K_FIVE;  w_sub = 1'b0; w_chan = i_blue;
            end else begin
                w_k = K_ONE;   w_sub = 1'b1; w_chan = i_green;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx   <= w_mx;
            r_mn   <= w_mn;
            r_chan <= w_chan;
            r_k    <= w_k;
            r_sub  <= w_sub;
        end
    end

    always_comb begin
        w_d  = r_mx - r_mn;
        w_t  = r_mx - r_chan;
        w_dx = NUM_W_EXT(w_d);
        w_d5 = w_dx + {w_dx[rhpq_pkg::NUM_W-3:0], 2'b00};
        case (r_k)
            K_THREE: w_kd = w_dx + {w_dx[rhpq_pkg::NUM_W-2:0], 1'b0};
            K_FIVE:  w_kd = w_d5;
            default: w_kd = w_dx;
        endcase
        w_num = r_sub ? (w_kd - NUM_W_EXT(w_t)) : (w_kd + NUM_W_EXT(w_t));
        w_side.grey   = (r_mx == '0) || (w_d5 < NUM_W_EXT(r_mx));
        w_side.hi_val = r_mx[rhpq_pkg::CH_W-1];
        w_side.hi_sat = {1'b0, w_d, 1'b0} > {2'b00, r_mx};
        if (r_mx < 8'd64) begin
            w_side.grey_code = rhpq_pkg::GREY_BLACK;
        end else if (r_mx > 8'd204) begin
            w_side.grey_code = rhpq_pkg::GREY_WHITE;
        end else if (r_mx[rhpq_pkg::CH_W-1]) begin
            w_side.grey_code = rhpq_pkg::GREY_LIGHT;
        end else begin
            w_side.grey_code = rhpq_pkg::GREY_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= w_num;
            r_span <= w_d;
            r_side <= w_side;
        end
    end

    assign o_vld  = r_vld2;
    assign o_num  = r_num;
    assign o_span = r_span;
    assign o_side = r_side;

endmodule
`default_nettype wire

@@ rtl/rhpq_div_pipe.sv @@
// Product stage and one-bit-per-stage restoring divider for the hue step.
`default_nettype none
module rhpq_div_pipe (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic [rhpq_pkg::Q_W-1:0]    i_q,
    input  wire logic                        i_vld,
    input  wire logic [rhpq_pkg::NUM_W-1:0]  i_num,
    input  wire logic [rhpq_pkg::CH_W-1:0]   i_span,
    input  wire rhpq_pkg::t_side             i_side,
    output logic                             o_vld,
    output logic [rhpq_pkg::QUO_W-1:0]       o_quo,
    output rhpq_pkg::t_side                  o_side
);

    localparam int NST = rhpq_pkg::QUO_W;

    logic [rhpq_pkg::PROD_W-1:0] r_rem  [0:NST];
    logic [rhpq_pkg::DIV_W-1:0]  r_dv   [0:NST];
    logic [rhpq_pkg::QUO_W-1:0]  r_quo  [0:NST];
    rhpq_pkg::t_side             r_side [0:NST];
    logic [NST:0]                r_vld;

    logic [rhpq_pkg::DIV_W-1:0]  w_span_x;
    logic [rhpq_pkg::DIV_W-1:0]  w_dv6;

    always_comb begin
        w_span_x = {{(rhpq_pkg::DIV_W - rhpq_pkg::CH_W){1'b0}}, i_span};
        w_dv6    = {w_span_x[rhpq_pkg::DIV_W-3:0], 2'b00} + {w_span_x[rhpq_pkg::DIV_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= rhpq_pkg::PROD_W'(i_q * i_num);
            r_dv[0]   <= w_dv6;
            r_quo[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar gi = 0; gi < NST; gi++) begin : g_stage
        localparam int SH = NST - 1 - gi;
        logic [rhpq_pkg::PROD_W-1:0] w_shift;
        logic                        w_ge;

        always_comb begin
            w_shift = {{(rhpq_pkg::PROD_W - rhpq_pkg::DIV_W){1'b0}}, r_dv[gi]} << SH;
            w_ge    = r_rem[gi] >= w_shift;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi+1]  <= w_ge ? (r_rem[gi] - w_shift) : r_rem[gi];
                r_dv[gi+1]   <= r_dv[gi];
                r_quo[gi+1]  <= {r_quo[gi][rhpq_pkg::QUO_W-2:0], w_ge};
                r_side[gi+1] <= r_side[gi];
            end
        end
    end

    assign o_vld  = r_vld[NST];
    assign o_quo  = r_quo[NST];
    assign o_side = r_side[NST];

endmodule
`default_nettype wire

@@ rtl/rgb_to_hsv_palette_quantizer_core.sv @@
// Top level: palette register, pipeline stall control and index assembly.
// Throughput: one pixel per cycle; the ten-stage datapath plus output register
// all advance together and hold while the output word waits.
// Reset: synchronous active low; clears all valid bits, q returns to 64.
`default_nettype none
module rgb_to_hsv_palette_quantizer_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [rhpq_pkg::Q_W-1:0]  i_cfg_wr_data,
    rhpq_pix_if.sink                       i_pix,
    rhpq_idx_if.source                     o_idx
);

    logic [rhpq_pkg::Q_W-1:0] r_q, n_q;
    logic                     w_en;

    logic                       w_f_vld;
    logic [rhpq_pkg::NUM_W-1:0] w_f_num;
    logic [rhpq_pkg::CH_W-1:0]  w_f_span;
    rhpq_pkg::t_side            w_f_side;

    logic                       w_d_vld;
    logic [rhpq_pkg::QUO_W-1:0] w_d_quo;
    rhpq_pkg::t_side            w_d_side;

    logic [rhpq_pkg::IDX_W-1:0] w_q8, w_q2, w_q3, w_step, w_idx;

    logic                       r_out_vld;
    logic [rhpq_pkg::IDX_W-1:0] r_out_idx;

    always_comb begin
        n_q = i_cfg_wr_data;
        if (i_cfg_wr_data < rhpq_pkg::Q_MIN) n_q = rhpq_pkg::Q_MIN;
        if (i_cfg_wr_data > rhpq_pkg::Q_MAX) n_q = rhpq_pkg::Q_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= rhpq_pkg::Q_RESET;
        end else if (i_cfg_wr_en) begin
            r_q <= n_q;
        end
    end

    assign w_en        = !r_out_vld || o_idx.ready;
    assign i_pix.ready = w_en;

    rhpq_hue_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pix.valid),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_vld   (w_f_vld),
        .o_num   (w_f_num),
        .o_span  (w_f_span),
        .o_side  (w_f_side)
    );

    rhpq_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_q     (r_q),
        .i_vld   (w_f_vld),
        .i_num   (w_f_num),
        .i_span  (w_f_span),
        .i_side  (w_f_side),
        .o_vld   (w_d_vld),
        .o_quo   (w_d_quo),
        .o_side  (w_d_side)
    );

    always_comb begin
        w_q8   = {1'b0, r_q};
        w_q2   = {r_q, 1'b0};
        w_q3   = w_q2 + w_q8;
        w_step = {1'b0, w_d_quo};
        if (w_step == '0) w_step = 8'd1;
        if (w_step >= w_q8) w_step = w_q8 - 8'd1;
        w_idx = w_step;
        if (w_d_side.hi_val) w_idx = w_idx + w_q2;
        if (w_d_side.hi_sat) w_idx = w_idx + w_q8;
        if (w_d_side.grey) begin
            case (w_d_side.grey_code)
                rhpq_pkg::GREY_WHITE: w_idx = w_q8;
                rhpq_pkg::GREY_LIGHT: w_idx = w_q3;
                rhpq_pkg::GREY_MID:   w_idx = w_q2;
                default:              w_idx = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_idx <= w_idx;
        end
    end

    assign o_idx.valid         = r_out_vld;
    assign o_idx.palette_index = r_out_idx;

    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q >= rhpq_pkg::Q_MIN) && (r_q <= rhpq_pkg::Q_MAX))
        else $error("palette quarter out of range");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_idx.valid |-> ({1'b0, o_idx.palette_index} < {r_q, 2'b00}))
        else $error("palette index beyond palette");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (o_idx.valid && !o_idx.ready))
        else $error("input stalled without a waiting output word");

endmodule
`default_nettype wire
